// ----- rtl/core/rpa_pkg.sv -----
package rpa_pkg;

  localparam int unsigned CoordWidth   = 32;
  localparam int unsigned AngleWidth   = 16;
  localparam int unsigned AxisWidth    = 16;
  localparam int unsigned CordicSteps  = 16;
  localparam int unsigned CordicWidth  = 34;
  localparam int unsigned TrigWidth    = 16;
  localparam int unsigned MatWidth     = 25;
  localparam int unsigned MatShift     = 22;
  localparam int unsigned OutShift     = 20;
  localparam logic signed [CordicWidth-1:0] CordicGain = 34'sd163008219;
  localparam logic signed [TrigWidth-1:0]   TrigOne    = 16'sd16384;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] point_x;
    logic signed [CoordWidth-1:0] point_y;
    logic signed [CoordWidth-1:0] point_z;
    logic signed [CoordWidth-1:0] centre_x;
    logic signed [CoordWidth-1:0] centre_y;
    logic signed [CoordWidth-1:0] centre_z;
    logic signed [AxisWidth-1:0]  axis_x;
    logic signed [AxisWidth-1:0]  axis_y;
    logic signed [AxisWidth-1:0]  axis_z;
    logic [AngleWidth-1:0]        turn_angle;
  } req_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] rotated_x;
    logic signed [CoordWidth-1:0] rotated_y;
    logic signed [CoordWidth-1:0] rotated_z;
    logic                         saturated;
  } rsp_t;

  function automatic logic signed [CordicWidth-1:0] atan_turn(input int unsigned i);
    logic signed [CordicWidth-1:0] r;
    case (i)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933406;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/rpa_cordic.sv -----
// pipelined sin/cos: input stage, one cordic step per stage, then quadrant and rounding stage
module rpa_cordic #(
  parameter int unsigned ANGLE_WIDTH = rpa_pkg::AngleWidth
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [ANGLE_WIDTH-1:0]               angle_i,
  output logic signed [rpa_pkg::TrigWidth-1:0] cos_o,
  output logic signed [rpa_pkg::TrigWidth-1:0] sin_o
);
  import rpa_pkg::*;

  localparam int unsigned N = CordicSteps;

  logic signed [CordicWidth-1:0] x_q [N+1];
  logic signed [CordicWidth-1:0] y_q [N+1];
  logic signed [CordicWidth-1:0] z_q [N+1];
  logic [1:0]                    quad_q [N+1];
  logic [31:0]                   phase;

  assign phase = {angle_i, {(32-ANGLE_WIDTH){1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CordicGain;
      y_q[0]    <= '0;
      z_q[0]    <= CordicWidth'({2'b00, phase[29:0]});
      quad_q[0] <= phase[31:30];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quad_q[i+1] <= quad_q[i];
        if (!z_q[i][CordicWidth-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_turn(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_turn(i);
        end
      end
    end
  end

  function automatic logic signed [TrigWidth-1:0] trig_round(
    input logic signed [CordicWidth-1:0] v);
    logic signed [CordicWidth-1:0] r;
    r = (v + CordicWidth'(8192)) >>> 14;
    if (r > CordicWidth'(TrigOne)) r = CordicWidth'(TrigOne);
    if (r < -CordicWidth'(TrigOne)) r = -CordicWidth'(TrigOne);
    return TrigWidth'(r);
  endfunction

  logic signed [CordicWidth-1:0] xc, yc;

  always_comb begin
    case (quad_e'(quad_q[N]))
      QUAD_0:  begin xc = x_q[N];  yc = y_q[N];  end
      QUAD_1:  begin xc = -y_q[N]; yc = x_q[N];  end
      QUAD_2:  begin xc = -x_q[N]; yc = -y_q[N]; end
      default: begin xc = y_q[N];  yc = -x_q[N]; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= trig_round(xc);
      sin_o <= trig_round(yc);
    end
  end

endmodule

// ----- rtl/core/rotate_point_about_axis_top.sv -----
// channel | valid       | stall       | payload
// request | req_valid_i | req_stall_o | req_i   (point, centre, axis, angle)
// result  | rsp_valid_o | rsp_stall_i | rsp_o   (rotated point, saturated flag)
//
// one request per cycle while the output is not stalled; 18 cordic stages
// (input, 16 steps, quadrant and rounding) plus 6 matrix and rotation stages.
// the whole pipeline advances together (global enable), so an output stall
// freezes every stage; req_stall_o is high exactly while a valid result waits
// at the output and rsp_stall_i is high.
// reset clears only the valid bits; the data path carries no reset.
module rotate_point_about_axis_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  rpa_pkg::req_t req_i,
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output rpa_pkg::rsp_t rsp_o
);
  import rpa_pkg::*;

  localparam int unsigned COORD_WIDTH = CoordWidth;
  localparam int unsigned ANGLE_WIDTH = AngleWidth;

  // cordic: 18 stages, then 6 stages here
  localparam int unsigned CDLY  = CordicSteps + 2;
  localparam int unsigned DW    = COORD_WIDTH + 1;       // p - c
  localparam int unsigned PW    = DW + MatWidth;         // product
  localparam int unsigned SW    = PW + 2;                // sum of three
  localparam int unsigned LAT   = CDLY + 6;
  localparam int unsigned EW    = 48;                    // matrix entry pre-round

  logic en;
  logic [LAT-1:0] vld_q;

  // stall everything only when output holds a waiting result
  assign en          = !(vld_q[LAT-1] && rsp_stall_i);
  assign req_stall_o = !en;
  assign rsp_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], req_valid_i};
    end
  end

  logic signed [TrigWidth-1:0] cos_w, sin_w;

  rpa_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic (
    .clk_i  (clk_i),
    .en_i   (en),
    .angle_i(req_i.turn_angle),
    .cos_o  (cos_w),
    .sin_o  (sin_w)
  );

  // differences, centre and axis delayed alongside the cordic
  logic signed [DW-1:0]          d_q  [CDLY][3];
  logic signed [COORD_WIDTH-1:0] c_q  [LAT-2][3];
  logic signed [AxisWidth-1:0]   u_q  [CDLY][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q[0][0] <= DW'(req_i.point_x) - DW'(req_i.centre_x);
      d_q[0][1] <= DW'(req_i.point_y) - DW'(req_i.centre_y);
      d_q[0][2] <= DW'(req_i.point_z) - DW'(req_i.centre_z);
      c_q[0][0] <= req_i.centre_x;
      c_q[0][1] <= req_i.centre_y;
      c_q[0][2] <= req_i.centre_z;
      u_q[0][0] <= req_i.axis_x;
      u_q[0][1] <= req_i.axis_y;
      u_q[0][2] <= req_i.axis_z;
      for (int s = 1; s < CDLY; s++) begin
        d_q[s] <= d_q[s-1];
        u_q[s] <= u_q[s-1];
      end
      for (int s = 1; s < LAT - 2; s++) c_q[s] <= c_q[s-1];
    end
  end

  // cordic output lines up with d_q[CDLY-1]; keep differences for later stages
  logic signed [DW-1:0] d2_q [3][3];

  // matrix stage a: axis products, 1-cos, sin*axis
  logic signed [TrigWidth:0]   omc_a_q;
  logic signed [TrigWidth-1:0] cos_a_q;
  logic signed [32:0]          uu_a_q [3][3];
  logic signed [32:0]          su_a_q [3];

  // matrix stage b: entry before rounding
  logic signed [EW-1:0] e_b_q [3][3];
  // stage c: rounded entry
  logic signed [MatWidth-1:0] m_c_q [3][3];
  // stage d: products
  logic signed [PW-1:0] p_d_q [3][3];
  // stage e: row sum, rounded, centre added
  logic signed [SW:0] r_e_q [3];

  function automatic int unsigned kidx(input int unsigned i, input int unsigned j);
    return 3 - i - j;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      omc_a_q <= (TrigWidth+1)'(TrigOne) - (TrigWidth+1)'(cos_w);
      cos_a_q <= cos_w;
      for (int i = 0; i < 3; i++) begin
        su_a_q[i] <= 33'(sin_w) * 33'(u_q[CDLY-1][i]);
        for (int j = 0; j < 3; j++)
          uu_a_q[i][j] <= 33'(u_q[CDLY-1][i]) * 33'(u_q[CDLY-1][j]);
      end
      d2_q[0] <= d_q[CDLY-1];
      d2_q[1] <= d2_q[0];
      d2_q[2] <= d2_q[1];

      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          if (i == j)
            e_b_q[i][j] <= EW'(omc_a_q) * EW'(uu_a_q[i][j])
                           + (EW'(cos_a_q) <<< 28);
          else if ((j + 3 - i) % 3 == 2)
            e_b_q[i][j] <= EW'(omc_a_q) * EW'(uu_a_q[i][j])
                           + (EW'(su_a_q[kidx(i, j)]) <<< 14);
          else
            e_b_q[i][j] <= EW'(omc_a_q) * EW'(uu_a_q[i][j])
                           - (EW'(su_a_q[kidx(i, j)]) <<< 14);
        end

      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          m_c_q[i][j] <= MatWidth'((e_b_q[i][j] + EW'(1 << (MatShift - 1))) >>> MatShift);

      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          p_d_q[i][j] <= PW'(d2_q[2][j]) * PW'(m_c_q[i][j]);

      for (int i = 0; i < 3; i++)
        r_e_q[i] <= (SW+1)'((SW'(p_d_q[i][0]) + SW'(p_d_q[i][1]) + SW'(p_d_q[i][2])
                    + SW'(1 << (OutShift - 1))) >>> OutShift)
                    + (SW+1)'(c_q[LAT-3][i]);
    end
  end

  // final stage: clip
  localparam logic signed [SW:0] MaxV = (SW+1)'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [SW:0] MinV = -MaxV - (SW+1)'(1);

  logic signed [COORD_WIDTH-1:0] o_q [3];
  logic                          sat_q;
  logic signed [COORD_WIDTH-1:0] o_d [3];
  logic                          sat_d;

  always_comb begin
    sat_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (r_e_q[i] > MaxV) begin
        o_d[i] = MaxV[COORD_WIDTH-1:0]; sat_d = 1'b1;
      end else if (r_e_q[i] < MinV) begin
        o_d[i] = MinV[COORD_WIDTH-1:0]; sat_d = 1'b1;
      end else begin
        o_d[i] = r_e_q[i][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_q   <= o_d;
      sat_q <= sat_d;
    end
  end

  always_comb begin
    rsp_o           = '0;
    rsp_o.rotated_x = o_q[0];
    rsp_o.rotated_y = o_q[1];
    rsp_o.rotated_z = o_q[2];
    rsp_o.saturated = sat_q;
  end

endmodule

// ----- test/rotate_point_checker.sv -----
`timescale 1ns / 1ps

module rotate_point_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_stall_i,
  input  rpa_pkg::req_t req_i,
  input  logic          rsp_valid_i,
  input  logic          rsp_stall_i,
  input  rpa_pkg::rsp_t rsp_i,
  output int unsigned   fail_count_o,
  output int unsigned   pending_o
);
  import rpa_pkg::*;

  rsp_t rotated_q[$];
  int unsigned fails;

  assign fail_count_o = fails;
  assign pending_o    = rotated_q.size();

  function automatic longint floor_sh(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint trig_q14(longint v);
    longint r;
    r = floor_sh(v + 8192, 14);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  function automatic rsp_t rotate_point(req_t rq);
    longint x, y, z, xs, ys, xc, yc, cv, sv, omc, v, sk;
    longint u[3];
    longint e[3][3];
    logic signed [CoordWidth-1:0] p[3], c[3];
    logic signed [127:0] acc, lo_b, hi_b;
    logic [31:0] ph;
    quad_e q;
    rsp_t r;
    ph = 32'(rq.turn_angle) << (32 - AngleWidth);
    q  = quad_e'(ph[31:30]);
    x = CordicGain; y = 0; z = longint'(ph[29:0]);
    for (int i = 0; i < CordicSteps; i++) begin
      xs = floor_sh(x, i);
      ys = floor_sh(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_turn(i));
      end else begin
        x += ys; y -= xs; z += longint'(atan_turn(i));
      end
    end
    case (q)
      QUAD_0: begin xc = x;  yc = y;  end
      QUAD_1: begin xc = -y; yc = x;  end
      QUAD_2: begin xc = -x; yc = -y; end
      default: begin xc = y; yc = -x; end
    endcase
    cv = trig_q14(xc);
    sv = trig_q14(yc);
    omc = 16384 - cv;
    u = '{longint'(rq.axis_x), longint'(rq.axis_y), longint'(rq.axis_z)};
    p = '{rq.point_x, rq.point_y, rq.point_z};
    c = '{rq.centre_x, rq.centre_y, rq.centre_z};
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        v = omc * u[i] * u[j];
        if (i == j) v += cv * (64'sd1 << 28);
        else begin
          sk = sv * u[3 - i - j] * 16384;
          v += ((j + 3 - i) % 3 == 2) ? sk : -sk;
        end
        e[i][j] = floor_sh(v + (64'sd1 << (MatShift - 1)), MatShift);
      end
    r.saturated = 1'b0;
    lo_b = -(128'sd1 <<< (CoordWidth - 1));
    hi_b = (128'sd1 <<< (CoordWidth - 1)) - 1;
    for (int i = 0; i < 3; i++) begin
      acc = '0;
      for (int j = 0; j < 3; j++)
        acc += (128'(signed'(p[j])) - 128'(signed'(c[j]))) * 128'(signed'(e[i][j]));
      acc = ((acc + (128'sd1 <<< (OutShift - 1))) >>> OutShift) + 128'(signed'(c[i]));
      if (acc > hi_b) begin acc = hi_b; r.saturated = 1'b1; end
      if (acc < lo_b) begin acc = lo_b; r.saturated = 1'b1; end
      case (i)
        0: r.rotated_x = acc[CoordWidth-1:0];
        1: r.rotated_y = acc[CoordWidth-1:0];
        default: r.rotated_z = acc[CoordWidth-1:0];
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      fails = 0;
      rotated_q.delete();
    end else begin
      if (req_valid_i && !req_stall_i) rotated_q.push_back(rotate_point(req_i));
      if (rsp_valid_i && !rsp_stall_i) begin
        if (rotated_q.size() == 0) report_mismatch("unexpected result", 0, 0);
        else begin
          want = rotated_q.pop_front();
          if (rsp_i.rotated_x !== want.rotated_x)
            report_mismatch("rotated_x", rsp_i.rotated_x, want.rotated_x);
          if (rsp_i.rotated_y !== want.rotated_y)
            report_mismatch("rotated_y", rsp_i.rotated_y, want.rotated_y);
          if (rsp_i.rotated_z !== want.rotated_z)
            report_mismatch("rotated_z", rsp_i.rotated_z, want.rotated_z);
          if (rsp_i.saturated !== want.saturated)
            report_mismatch("saturated", rsp_i.saturated, want.saturated);
        end
      end
    end
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import rpa_pkg::*;

  localparam int unsigned NumRandom  = 1950;
  localparam int unsigned DrainWait  = 60;     // pipeline depth is about 24
  localparam longint      CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  int unsigned fail_count, pending;
  longint cycles = 0;

  // idle percentages for sender and receiver
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rotate_point_about_axis_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_stall_o(req_stall),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_stall_i(rsp_stall),
    .rsp_o      (rsp)
  );

  rotate_point_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_stall_i (req_stall),
    .req_i       (req),
    .rsp_valid_i (rsp_valid),
    .rsp_stall_i (rsp_stall),
    .rsp_i       (rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // receiver stalls at random, decided per edge
  always @(posedge clk_i) begin
    rsp_stall <= ($urandom_range(99) < recv_stall);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      3: return 32'($signed($urandom_range(200000)) - 100000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(4))
      0: return 16'd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);     // full 16-bit range, non-unit too
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  // one request: hold until accepted, random idle beforehand
  task automatic send_rotation(req_t item);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk_i);
    while (req_stall) @(posedge clk_i);
  endtask

  task automatic go_idle();
    req_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    go_idle();
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic req_t rand_item();
    req_t it;
    it.point_x  = rand_coord();
    it.point_y  = rand_coord();
    it.point_z  = rand_coord();
    it.centre_x = rand_coord();
    it.centre_y = rand_coord();
    it.centre_z = rand_coord();
    it.axis_x   = rand_axis();
    it.axis_y   = rand_axis();
    it.axis_z   = rand_axis();
    it.turn_angle = ($urandom_range(3) == 0) ? 16'($urandom_range(3)) << 14 : 16'($urandom);
    return it;
  endfunction

  initial begin
    req_t it;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: cardinal angles about each unit axis, zero axis, extremes
    for (int a = 0; a < 4; a++)
      for (int k = 0; k < 3; k++) begin
        it = '0;
        it.point_x = 32'sd65536; it.point_y = 32'sd131072; it.point_z = -32'sd196608;
        it.centre_x = 32'sd16; it.centre_y = -32'sd32;
        it.axis_x = (k == 0) ? 16'sd16384 : '0;
        it.axis_y = (k == 1) ? 16'sd16384 : '0;
        it.axis_z = (k == 2) ? -16'sd16384 : '0;
        it.turn_angle = 16'(a) << 14;
        send_rotation(it);
      end
    it = '0;                                    // zero axis, scale about centre
    it.point_x = 32'sd1000000; it.turn_angle = 16'h2000;
    send_rotation(it);
    it = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
           32'h8000_0000, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff};
    send_rotation(it);                          // extreme values toward the upper bound
    it = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
           32'h7fff_ffff, 16'h8000, 16'h8000, 16'h8000, 16'h0001};
    send_rotation(it);                          // extreme values toward the lower bound, most negative axis
    it = '{32'hffff_ffff, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0, 16'h0};
    send_rotation(it);
    // sender holds off until the pipe is empty
    wait_drained();

    // random phases: none, sender idle, receiver stall, both, none again
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin send_idle = 85; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 85; end
        3: begin send_idle = 33; recv_stall = 33; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      for (int n = 0; n < NumRandom / 5; n++) send_rotation(rand_item());
    end
    send_idle = 0;
    wait_drained();
    recv_stall = 0;
    repeat (DrainWait) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
